// File: hdl/lzd_pkg.sv
// Shared types and constants for the LZ77 stream decompressor.
// No dependencies; imported by every module of the block.
package lzd_pkg;

	localparam int WIN_AW      = 12;
	localparam int WINDOW_SIZE = 1 << WIN_AW;
	localparam int BL_W        = 24;
	localparam int CNT_W       = 5;
	localparam int Q_AW        = 1;
	localparam int Q_DEPTH     = 1 << Q_AW;

	localparam logic [2:0] PH_TYPE = 3'd0;
	localparam logic [2:0] PH_SZ0  = 3'd1;
	localparam logic [2:0] PH_SZ1  = 3'd2;
	localparam logic [2:0] PH_SZ2  = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;

	localparam logic [CNT_W-1:0] MIN_MATCH = CNT_W'(3);

	typedef struct packed {
		logic              is_copy;
		logic [7:0]        lit;
		logic [CNT_W-1:0]  cnt;
		logic [WIN_AW:0]   offs;
		logic              last;
	} lzd_cmd_t;

endpackage

// File: hdl/lzd_front.sv
// Front end: header, flag and pair parsing; tracks bytes owed.
// Emits literal/copy commands. Depends on lzd_pkg.
module lzd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            q_push,
	output lzd_pkg::lzd_cmd_t q_cmd
);
	import lzd_pkg::*;

	logic [2:0]      phase_q, phase_n;
	logic [BL_W-1:0] bl_q, bl_n;
	logic [7:0]      flag_bits_q, flag_bits_n;
	logic [3:0]      flags_left_q, flags_left_n;
	logic [7:0]      pair_hi_q, pair_hi_n;
	logic            pend_q, pend_n;
	logic            in_go;

	assign in_stall = q_full;
	assign in_go    = in_valid && !q_full;

	always_comb begin
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] clip;
		logic             overrun;
		logic             done;
		logic             consume;
		phase_n      = phase_q;
		bl_n         = bl_q;
		flag_bits_n  = flag_bits_q;
		flags_left_n = flags_left_q;
		pair_hi_n    = pair_hi_q;
		pend_n       = pend_q;
		q_push       = 1'b0;
		q_cmd        = '0;
		done         = 1'b0;
		consume      = 1'b0;
		len          = CNT_W'(pair_hi_q[7:4]) + MIN_MATCH;
		overrun      = bl_q <= BL_W'(len);
		clip         = overrun ? bl_q[CNT_W-1:0] : len;
		if (in_go) begin
			unique case (phase_q)
				PH_TYPE: begin
					flags_left_n = '0;
					flag_bits_n  = '0;
					pend_n       = 1'b0;
					phase_n      = PH_SZ0;
				end
				PH_SZ0: begin
					bl_n    = BL_W'(in_byte);
					phase_n = PH_SZ1;
				end
				PH_SZ1: begin
					bl_n[15:8] = in_byte;
					phase_n    = PH_SZ2;
				end
				PH_SZ2: begin
					bl_n[23:16] = in_byte;
					if ({in_byte, bl_q[15:0]} == '0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					if (bl_q == '0) begin
						done = 1'b1;
					end else if (pend_q) begin
						pend_n        = 1'b0;
						q_push        = 1'b1;
						q_cmd.is_copy = 1'b1;
						q_cmd.cnt     = clip;
						q_cmd.offs    = {1'b0, pair_hi_q[3:0], in_byte} + (WIN_AW+1)'(1);
						q_cmd.last    = overrun;
						bl_n          = bl_q - BL_W'(clip);
						done          = overrun;
						consume       = 1'b1;
					end else if (flags_left_q == '0) begin
						flag_bits_n  = in_byte;
						flags_left_n = 4'd8;
					end else if (flag_bits_q[7]) begin
						pair_hi_n = in_byte;
						pend_n    = 1'b1;
					end else begin
						q_push     = 1'b1;
						q_cmd.lit  = in_byte;
						q_cmd.cnt  = CNT_W'(1);
						q_cmd.last = bl_q == BL_W'(1);
						bl_n       = bl_q - BL_W'(1);
						done       = q_cmd.last;
						consume    = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (consume) begin
				flag_bits_n = {flag_bits_q[6:0], 1'b0};
				if (flags_left_q != '0) begin
					flags_left_n = flags_left_q - 4'd1;
				end
			end
			if (done) begin
				phase_n      = PH_TYPE;
				flags_left_n = '0;
				flag_bits_n  = '0;
				pend_n       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			bl_q         <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			pair_hi_q    <= '0;
			pend_q       <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			bl_q         <= bl_n;
			flag_bits_q  <= flag_bits_n;
			flags_left_q <= flags_left_n;
			pair_hi_q    <= pair_hi_n;
			pend_q       <= pend_n;
		end
	end

endmodule

// File: hdl/lzd_cmd_fifo.sv
// Short command queue between the parser and the copy engine.
// Depends on lzd_pkg.
module lzd_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lzd_pkg::lzd_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output lzd_pkg::lzd_cmd_t head_cmd
);
	import lzd_pkg::*;

	lzd_cmd_t      ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full       = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

endmodule

// File: hdl/lzd_back.sv
// Copy engine: history window memory, byte emission, output register.
// Depends on lzd_pkg.
module lzd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  lzd_pkg::lzd_cmd_t head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              stream_end
);
	import lzd_pkg::*;

	logic [7:0]        win_mem [WINDOW_SIZE];
	logic [WIN_AW-1:0] wpos_q;
	logic [WIN_AW:0]   fill_q, fill_nxt;
	logic              busy_q;
	logic [WIN_AW-1:0] src_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIN_AW:0]   dist_q;
	logic              end_q;
	logic [7:0]        rd_raw_q, rd_fwd_q;
	logic              fwd_sel_q, rd_zero_q;
	logic              ov_q, slot_free;
	logic              lit_go, fetch, emit_copy, emit, rd_en, more;
	logic [WIN_AW-1:0] rd_addr;
	logic [7:0]        emit_byte, copy_byte;

	assign slot_free = !ov_q || !out_stall;
	assign lit_go    = !busy_q && head_valid && !head_cmd.is_copy && slot_free;
	assign fetch     = !busy_q && head_valid && head_cmd.is_copy;
	assign pop       = lit_go || fetch;
	assign emit_copy = busy_q && slot_free;
	assign emit      = lit_go || emit_copy;
	assign more      = cnt_q != CNT_W'(1);
	assign copy_byte = rd_zero_q ? 8'd0 : (fwd_sel_q ? rd_fwd_q : rd_raw_q);
	assign emit_byte = busy_q ? copy_byte : head_cmd.lit;
	assign fill_nxt  = (fill_q == (WIN_AW+1)'(WINDOW_SIZE)) ? fill_q
		: fill_q + (WIN_AW+1)'(1);
	assign rd_en     = fetch || (emit_copy && more);
	assign rd_addr   = fetch ? wpos_q - head_cmd.offs[WIN_AW-1:0] : src_q + WIN_AW'(1);

	always_ff @(posedge clk) begin
		if (emit) begin
			win_mem[wpos_q] <= emit_byte;
		end
		if (rd_en) begin
			rd_raw_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_fwd_q  <= emit_byte;
			fwd_sel_q <= emit && (rd_addr == wpos_q);
			rd_zero_q <= fetch ? (head_cmd.offs > fill_q) : (dist_q > fill_nxt);
		end
		if (fetch) begin
			cnt_q  <= head_cmd.cnt;
			dist_q <= head_cmd.offs;
			end_q  <= head_cmd.last;
		end else if (emit_copy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (rd_en) begin
			src_q <= rd_addr;
		end
		if (emit) begin
			out_byte   <= emit_byte;
			run_last   <= busy_q ? !more : 1'b1;
			stream_end <= busy_q ? (!more && end_q) : head_cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			wpos_q <= '0;
			fill_q <= '0;
		end else begin
			if (fetch) begin
				busy_q <= 1'b1;
			end else if (emit_copy && !more) begin
				busy_q <= 1'b0;
			end
			if (slot_free) begin
				ov_q <= emit;
			end
			if (emit) begin
				wpos_q <= wpos_q + WIN_AW'(1);
				fill_q <= fill_nxt;
			end
		end
	end

	assign out_valid = ov_q;

endmodule

// File: hdl/lz77_stream_decompressor_core.sv
// LZ77 (LZ10 format) stream decompressor, top level.
// Depends on lzd_pkg, lzd_front, lzd_cmd_fifo, lzd_back.
//
// One compressed byte per input word; one decompressed byte per output word.
// Header, flag and first-of-pair bytes are consumed by the parser and make
// no output. A literal is emitted directly by the copy engine; a pair of
// length n (3..18, clipped at the declared size) first starts the read of the
// 4096-byte history window (one write and one read port), then emits one byte
// per cycle while the output is not stalled. A two-entry command queue lets
// the parser run ahead of the copy engine. The window is never cleared: window
// slots not yet written since reset read as zero, tracked by a saturating fill
// count, so the block is ready at once.
module lz77_stream_decompressor_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       stream_end
);
	import lzd_pkg::*;

	lzd_cmd_t push_cmd, head_cmd;
	logic     q_push, q_full, q_pop, head_valid;

	lzd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	lzd_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	lzd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

endmodule
